[rtl/core/distance_vector_route_update_defines.svh]
// ----------------------------------------------------------------------------
// Distance-vector route update: assertion macros
// Shared property forms for the port checker, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH

// Same-cycle implication.
`define DVR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvr port check failed");

// Next-cycle implication.
`define DVR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvr port check failed");

`endif

[rtl/core/dvr_pkg.sv]
// ----------------------------------------------------------------------------
// Distance-vector route update: package
// Field widths, codes, request and result types, and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package dvr_pkg;

    localparam int MODE_W     = 2;
    localparam int DEST_W     = 4;
    localparam int COST_W     = 10;
    localparam int METHOD_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int NODE_COUNT_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam logic [COST_W-1:0] INFINITE_COST     = 10'd999;
    localparam logic [COST_W-1:0] COUNT_LIMIT_RESET = 10'd100;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECEIVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVERTISE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP       = 2'd3;

    // Advertisement methods
    localparam logic [METHOD_W-1:0] METHOD_PLAIN  = 2'd0;
    localparam logic [METHOD_W-1:0] METHOD_POISON = 2'd1;
    localparam logic [METHOD_W-1:0] METHOD_SPLIT  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADVERT_METHOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT   = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DEST_W-1:0] destination;
        logic [DEST_W-1:0] peer;
        logic [COST_W-1:0] cost;
        logic              hop_valid;
    } dvr_req_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest_out;
        logic [COST_W-1:0] cost_out;
        logic [DEST_W-1:0] next_hop;
        logic              next_hop_known;
        logic              suppressed;
        logic              updated;
        logic              over_limit;
        logic              any_over_limit;
        logic              last;
    } dvr_rsp_t;

    typedef struct packed {
        logic              known;
        logic [DEST_W-1:0] hop;
        logic [COST_W-1:0] cost;
    } dvr_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RX_READ,
        ST_RX_RELAX,
        ST_SW_READ,
        ST_SW_EMIT
    } dvr_state_t;

    typedef struct packed {
        logic accept;
        logic rd_relax;
        logic rd_sweep;
        logic emit_load;
        logic emit_relax;
        logic emit_sweep;
    } dvr_cmd_t;

    typedef struct packed {
        logic out_free;
        logic sweep_last;
    } dvr_sts_t;

endpackage

`default_nettype wire

[rtl/core/dvr_ctrl.sv]
// ----------------------------------------------------------------------------
// Distance-vector route update: controller
// Sequences load, receive and advertise requests over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_ctrl
    import dvr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic [MODE_W-1:0] req_mode,
    output logic                   req_stall,
    input  wire dvr_sts_t          sts,
    output dvr_cmd_t               cmd
);

    dvr_state_t state_reg;
    dvr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_mode)
                        MODE_LOAD:      state_next = ST_LOAD;
                        MODE_RECEIVE:   state_next = ST_RX_READ;
                        MODE_ADVERTISE: state_next = ST_SW_READ;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RX_READ:
            begin
                state_next = ST_RX_RELAX;
            end
            ST_RX_RELAX:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SW_READ:
            begin
                state_next = ST_SW_EMIT;
            end
            ST_SW_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.sweep_last ? ST_IDLE : ST_SW_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_LOAD:
            begin
                cmd.emit_load = sts.out_free;
            end
            ST_RX_READ:
            begin
                cmd.rd_relax = 1'b1;
            end
            ST_RX_RELAX:
            begin
                cmd.emit_relax = sts.out_free;
            end
            ST_SW_READ:
            begin
                cmd.rd_sweep = 1'b1;
            end
            ST_SW_EMIT:
            begin
                cmd.emit_sweep = sts.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/dvr_dpath.sv]
// ----------------------------------------------------------------------------
// Distance-vector route update: datapath
// Route table memory, configuration registers, relaxation, sweep logic
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_dpath
    import dvr_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dvr_req_t              req_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire dvr_cmd_t              cmd,
    output dvr_sts_t                   sts,
    input  wire logic                  rsp_stall,
    output logic                       rsp_valid,
    output dvr_rsp_t                   rsp_data
);

    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int CMP_W   = ADDR_W + DEST_W;
    localparam int SWEEP_N = (NODE_COUNT < MAX_RESULTS) ? NODE_COUNT : MAX_RESULTS;
    localparam logic [CMP_W-1:0]  NODE_LIM   = CMP_W'(NODE_COUNT);
    localparam logic [DEST_W-1:0] SWEEP_LAST = DEST_W'(SWEEP_N - 1);

    logic [METHOD_W-1:0] method_reg;
    logic [COST_W-1:0]   limit_reg;
    dvr_req_t            hold_reg;
    dvr_entry_t          rd_a_reg;
    dvr_entry_t          rd_b_reg;
    logic [DEST_W-1:0]   sweep_cnt_reg;
    logic                seen_reg;
    logic                rsp_valid_reg;
    dvr_rsp_t            rsp_data_reg;

    dvr_entry_t route_mem [NODE_COUNT];

    logic [CMP_W-1:0]  dest_ext;
    logic [CMP_W-1:0]  peer_ext;
    logic [CMP_W-1:0]  sweep_ext;
    logic [ADDR_W-1:0] addr_dest;
    logic [ADDR_W-1:0] addr_peer;
    logic [ADDR_W-1:0] addr_b;
    logic              dest_ok;
    logic              peer_ok;
    logic [COST_W-1:0] in_cost;
    logic [COST_W-1:0] own_cost;
    logic [COST_W:0]   sum_raw;
    logic [COST_W-1:0] sum_cost;
    logic              better;
    logic              via;
    logic              sweep_ov;
    logic              mem_we;
    dvr_entry_t        wr_entry;
    dvr_rsp_t          load_rsp;
    dvr_rsp_t          relax_rsp;
    dvr_rsp_t          sweep_rsp;
    logic              emit;

    function automatic logic over_limit_f(input logic [COST_W-1:0] c,
                                          input logic [COST_W-1:0] lim);
        over_limit_f = (c > lim) && (c < INFINITE_COST);
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METHOD_PLAIN;
            limit_reg  <= COUNT_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ADVERT_METHOD)
            begin
                method_reg <= cfg_data[METHOD_W-1:0];
            end
            else
            begin
                limit_reg <= cfg_data[COST_W-1:0];
            end
        end
    end

    // Hold the accepted request, cost saturated at infinity
    assign in_cost = (req_data.cost > INFINITE_COST) ? INFINITE_COST : req_data.cost;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hold_reg <= '{mode: req_data.mode, destination: req_data.destination,
                          peer: req_data.peer, cost: in_cost,
                          hop_valid: req_data.hop_valid};
        end
    end

    assign dest_ext  = {{ADDR_W{1'b0}}, hold_reg.destination};
    assign peer_ext  = {{ADDR_W{1'b0}}, hold_reg.peer};
    assign sweep_ext = {{ADDR_W{1'b0}}, sweep_cnt_reg};
    assign addr_dest = dest_ext[ADDR_W-1:0];
    assign addr_peer = peer_ext[ADDR_W-1:0];
    assign dest_ok   = dest_ext < NODE_LIM;
    assign peer_ok   = peer_ext < NODE_LIM;
    assign addr_b    = cmd.rd_sweep ? sweep_ext[ADDR_W-1:0] : addr_dest;

    // Route table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            route_mem[addr_dest] <= wr_entry;
        end
        if (cmd.rd_relax)
        begin
            rd_a_reg <= route_mem[addr_peer];
        end
        if (cmd.rd_relax || cmd.rd_sweep)
        begin
            rd_b_reg <= route_mem[addr_b];
        end
    end

    // Relaxation: own cost to sender plus advertised cost, saturated
    assign own_cost = peer_ok ? rd_a_reg.cost : INFINITE_COST;
    assign sum_raw  = {1'b0, own_cost} + {1'b0, hold_reg.cost};
    assign sum_cost = (sum_raw > {1'b0, INFINITE_COST}) ? INFINITE_COST
                                                        : sum_raw[COST_W-1:0];
    assign better   = sum_cost < rd_b_reg.cost;

    always_comb
    begin
        mem_we   = 1'b0;
        wr_entry = '{known: hold_reg.hop_valid, hop: hold_reg.peer, cost: hold_reg.cost};
        if (cmd.emit_load)
        begin
            mem_we = dest_ok;
        end
        else if (cmd.emit_relax)
        begin
            mem_we   = dest_ok && better;
            wr_entry = '{known: 1'b1, hop: hold_reg.peer, cost: sum_cost};
        end
    end

    always_comb
    begin
        load_rsp          = '0;
        load_rsp.dest_out = hold_reg.destination;
        load_rsp.last     = 1'b1;
        load_rsp.cost_out = INFINITE_COST;
        if (dest_ok)
        begin
            load_rsp.cost_out       = hold_reg.cost;
            load_rsp.next_hop       = hold_reg.peer;
            load_rsp.next_hop_known = hold_reg.hop_valid;
            load_rsp.over_limit     = over_limit_f(hold_reg.cost, limit_reg);
        end
    end

    always_comb
    begin
        relax_rsp          = '0;
        relax_rsp.dest_out = hold_reg.destination;
        relax_rsp.last     = 1'b1;
        relax_rsp.cost_out = INFINITE_COST;
        if (dest_ok)
        begin
            relax_rsp.cost_out       = better ? sum_cost : rd_b_reg.cost;
            relax_rsp.next_hop       = better ? hold_reg.peer : rd_b_reg.hop;
            relax_rsp.next_hop_known = better || rd_b_reg.known;
            relax_rsp.updated        = better;
            relax_rsp.over_limit     = over_limit_f(relax_rsp.cost_out, limit_reg);
        end
    end

    // Advertisement of one table entry to the neighbor in hold_reg.peer
    assign via = rd_b_reg.known && (rd_b_reg.hop == hold_reg.peer)
                 && (sweep_cnt_reg != hold_reg.peer);
    assign sweep_ov = over_limit_f(rd_b_reg.cost, limit_reg);

    always_comb
    begin
        sweep_rsp                = '0;
        sweep_rsp.dest_out       = sweep_cnt_reg;
        sweep_rsp.cost_out       = rd_b_reg.cost;
        sweep_rsp.next_hop       = rd_b_reg.hop;
        sweep_rsp.next_hop_known = rd_b_reg.known;
        sweep_rsp.over_limit     = sweep_ov;
        sweep_rsp.last           = sts.sweep_last;
        sweep_rsp.any_over_limit = sts.sweep_last && (seen_reg || sweep_ov);
        if (via && (method_reg == METHOD_POISON))
        begin
            sweep_rsp.cost_out = INFINITE_COST;
        end
        else if (via && (method_reg == METHOD_SPLIT))
        begin
            sweep_rsp.suppressed = 1'b1;
        end
    end

    // Sweep position and over-limit accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else if (cmd.accept)
        begin
            sweep_cnt_reg <= '0;
            if (req_data.mode == MODE_ADVERTISE)
            begin
                seen_reg <= 1'b0;
            end
        end
        else if (cmd.emit_sweep)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            seen_reg      <= seen_reg || sweep_ov;
        end
    end

    assign sts = '{out_free: !rsp_valid_reg || !rsp_stall,
                   sweep_last: sweep_cnt_reg == SWEEP_LAST};

    // Result register
    assign emit = cmd.emit_load || cmd.emit_relax || cmd.emit_sweep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            rsp_data_reg <= load_rsp;
        end
        else if (cmd.emit_relax)
        begin
            rsp_data_reg <= relax_rsp;
        end
        else if (cmd.emit_sweep)
        begin
            rsp_data_reg <= sweep_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

[rtl/core/distance_vector_route_update.sv]
// ----------------------------------------------------------------------------
// Distance-vector route update: top level
// One router's cost and next-hop table with load, receive and advertise.
// ----------------------------------------------------------------------------
// A request on req_data selects a mode. Load writes one table entry and
// returns it. Receive adds the stored cost to the sender to the advertised
// cost (saturating at 999), keeps the sum with the sender as next hop when it
// is strictly lower, and returns the entry, with updated set if it improved.
// Advertise sweeps the table in destination order, one result per entry,
// applying poisoned reverse or split horizon as set in advert_method; the
// last result carries last and the over-limit summary of the sweep. Mode
// three is dropped with no result. Load registers its result from the held
// request; receive first does the registered reads of the sender and
// destination entries, then relaxes and writes back; advertise does, for each
// entry, a registered table read followed by the result load. The table has
// one write and two read ports and no reset: read only entries already
// loaded. No clearing pass runs after reset. Configuration writes are always
// taken (cfg_ready high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update
    import dvr_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire dvr_req_t              req_data,

    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output dvr_rsp_t                   rsp_data,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dvr_cmd_t cmd;
    dvr_sts_t sts;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Sequence each request through the datapath
    dvr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req_data.mode),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the table, the registers and the result stage
    dvr_dpath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

[rtl/core/dvr_port_checker.sv]
// ----------------------------------------------------------------------------
// Distance-vector route update: port checker
// Assertions over the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_route_update_defines.svh"

module dvr_port_checker
    import dvr_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_stall,
    input wire dvr_req_t req_data,
    input wire logic     rsp_valid,
    input wire logic     rsp_stall,
    input wire dvr_rsp_t rsp_data
);

    // A taken request that yields results keeps the input side busy
    `DVR_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall && (req_data.mode != MODE_NOP), req_stall)

    // The sweep summary appears only on the final result
    `DVR_ASSERT_NOW(a_any_on_last, rsp_valid && rsp_data.any_over_limit, rsp_data.last)

    // An improved entry always has a known next hop and is never suppressed
    `DVR_ASSERT_NOW(a_upd_known, rsp_valid && rsp_data.updated, rsp_data.next_hop_known && !rsp_data.suppressed)

    // A stalled result holds
    `DVR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind distance_vector_route_update dvr_port_checker u_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/sv/distance_vector_route_update_tb.sv]
// ----------------------------------------------------------------------------
// Distance-vector route update: self-checking testbench
// Drives load, receive and advertise requests through the request channel.
// A shadow routing table inside the bench predicts every result, and a
// monitor compares each result with the oldest prediction, field by field.
// The run steps through every advertisement method and several count limits,
// from a zero limit to the highest one. It uses bursty request traffic, a
// varying result stall and one long result hold-off.
// ----------------------------------------------------------------------------

module distance_vector_route_update_tb;
    import dvr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Table size and sweep length as built into the block
    localparam int TABLE_DEPTH = NODE_COUNT_DEF;
    localparam int SWEEP_LEN   = (NODE_COUNT_DEF < MAX_RESULTS) ? NODE_COUNT_DEF : MAX_RESULTS;

    // Reserved method code: the block treats it as plain
    localparam logic [METHOD_W-1:0] METHOD_RESERVED = 2'd3;

    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_REQUESTS  = 67;
    localparam int SETTLE_CYCLES   = 40;    // covers the longest sweep
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    dvr_req_t              req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    dvr_rsp_t              rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow routing table and register copies
    dvr_entry_t          route_table [TABLE_DEPTH];
    logic [METHOD_W-1:0] advert_method_q = METHOD_PLAIN;
    logic [COST_W-1:0]   count_limit_q   = COUNT_LIMIT_RESET;

    dvr_req_t pending_requests [$];
    dvr_rsp_t expected_routes [$];

    int   mismatch_count = 0;
    bit   req_fire       = 1'b0;
    bit   hold_off_arm   = 1'b0;

    distance_vector_route_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Append to the tail of the request and result queues
    function automatic void queue_request(dvr_req_t r);
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    function automatic void expect_route(dvr_rsp_t rsp);
        expected_routes.insert(expected_routes.size(), rsp);
    endfunction

    // ------------------------------------------------------------------------
    // Route prediction
    // ------------------------------------------------------------------------

    function automatic logic cost_over_limit(logic [COST_W-1:0] cost);
        return (cost > count_limit_q) && (cost < INFINITE_COST);
    endfunction

    // Apply one accepted request to the shadow table and queue its results.
    function automatic void predict_route_results(dvr_req_t r);
        dvr_rsp_t          rsp;
        dvr_entry_t        entry;
        logic [COST_W-1:0] in_cost;
        logic [COST_W:0]   relaxed;
        logic              via;
        logic              seen;
        in_cost = (r.cost > INFINITE_COST) ? INFINITE_COST : r.cost;
        rsp = '0;
        unique case (r.mode)
            MODE_LOAD:
            begin
                entry.known = r.hop_valid;
                entry.hop   = r.peer;
                entry.cost  = in_cost;
                route_table[r.destination] = entry;
                rsp.dest_out       = r.destination;
                rsp.cost_out       = in_cost;
                rsp.next_hop       = r.peer;
                rsp.next_hop_known = r.hop_valid;
                rsp.over_limit     = cost_over_limit(in_cost);
                rsp.last           = 1'b1;
                expect_route(rsp);
            end
            MODE_RECEIVE:
            begin
                // Bellman-Ford relaxation through the sender, saturated at infinity
                relaxed = {1'b0, route_table[r.peer].cost} + {1'b0, in_cost};
                if (relaxed > INFINITE_COST)
                    relaxed = {1'b0, INFINITE_COST};
                if (relaxed[COST_W-1:0] < route_table[r.destination].cost)
                begin
                    route_table[r.destination].cost  = relaxed[COST_W-1:0];
                    route_table[r.destination].hop   = r.peer;
                    route_table[r.destination].known = 1'b1;
                    rsp.updated = 1'b1;
                end
                entry = route_table[r.destination];
                rsp.dest_out       = r.destination;
                rsp.cost_out       = entry.cost;
                rsp.next_hop       = entry.hop;
                rsp.next_hop_known = entry.known;
                rsp.over_limit     = cost_over_limit(entry.cost);
                rsp.last           = 1'b1;
                expect_route(rsp);
            end
            MODE_ADVERTISE:
            begin
                seen = 1'b0;
                for (int d = 0; d < SWEEP_LEN; d++)
                begin
                    rsp   = '0;
                    entry = route_table[d];
                    // Route learned from this neighbor, other than the neighbor itself
                    via = entry.known && (entry.hop == r.peer) && (d != r.peer);
                    rsp.dest_out       = d[DEST_W-1:0];
                    rsp.cost_out       = (via && advert_method_q == METHOD_POISON)
                                         ? INFINITE_COST : entry.cost;
                    rsp.suppressed     = via && (advert_method_q == METHOD_SPLIT);
                    rsp.next_hop       = entry.hop;
                    rsp.next_hop_known = entry.known;
                    rsp.over_limit     = cost_over_limit(entry.cost);
                    seen               = seen | rsp.over_limit;
                    rsp.last           = (d == SWEEP_LEN - 1);
                    rsp.any_over_limit = rsp.last && seen;
                    expect_route(rsp);
                end
            end
            default:
            begin
                // Mode three: dropped by the block, nothing to expect
            end
        endcase
    endfunction

    // Sample request and configuration handshakes at the rising edge.
    // req_fire tells the driver at the next falling edge that its request went in.
    always @(posedge clk)
    begin
        req_fire = rst_n && req_valid && !req_stall;
        if (req_fire)
            predict_route_results(req_data);
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ADVERT_METHOD)
                advert_method_q = cfg_data[METHOD_W-1:0];
            else
                count_limit_q = cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------------

    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_fire)
        begin
            // Hold a stalled request; only advance once the last one went in
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                req_data  <= pending_requests.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    // A quarter of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall pattern of its own plus one long hold-off
    // ------------------------------------------------------------------------

    stall_style_t stall_style = STALL_NONE;
    int           style_left  = 0;
    int           hold_left   = 0;
    bit           hold_done   = 1'b0;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
            if (hold_left == 0)
                hold_done = 1'b1;
        end
        else if (hold_off_arm && !hold_done)
        begin
            // Back up the block until it stalls its request side
            hold_left = HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(20, 80);
            end
            else
                style_left--;
            unique case (stall_style)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:     rsp_stall <= ~rsp_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        dvr_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_routes.size() == 0)
            begin
                $error("result with none expected: dest_out %0d cost_out %0d",
                       rsp_data.dest_out, rsp_data.cost_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_routes.pop_front();
                compare_field("dest_out", 16'(want.dest_out),
                              16'(rsp_data.dest_out));
                compare_field("cost_out", 16'(want.cost_out),
                              16'(rsp_data.cost_out));
                compare_field("next_hop", 16'(want.next_hop),
                              16'(rsp_data.next_hop));
                compare_field("next_hop_known", 16'(want.next_hop_known),
                              16'(rsp_data.next_hop_known));
                compare_field("suppressed", 16'(want.suppressed),
                              16'(rsp_data.suppressed));
                compare_field("updated", 16'(want.updated),
                              16'(rsp_data.updated));
                compare_field("over_limit", 16'(want.over_limit),
                              16'(rsp_data.over_limit));
                compare_field("any_over_limit", 16'(want.any_over_limit),
                              16'(rsp_data.any_over_limit));
                compare_field("last", 16'(want.last),
                              16'(rsp_data.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no handshake completes for too long
    // ------------------------------------------------------------------------

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic dvr_req_t make_request(logic [MODE_W-1:0] mode,
                                              logic [DEST_W-1:0] destination,
                                              logic [DEST_W-1:0] peer,
                                              logic [COST_W-1:0] cost,
                                              logic hop_valid);
        dvr_req_t r;
        r.mode        = mode;
        r.destination = destination;
        r.peer        = peer;
        r.cost        = cost;
        r.hop_valid   = hop_valid;
        return r;
    endfunction

    // Mostly relaxation traffic with short costs, so routes keep improving;
    // loads reset entries to long or unreachable costs now and then.
    function automatic dvr_req_t random_request();
        dvr_req_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            r.mode = MODE_LOAD;
        else if (pick < 78)
            r.mode = MODE_RECEIVE;
        else
            r.mode = MODE_ADVERTISE;
        r.destination = DEST_W'($urandom_range(0, 15));
        r.peer        = DEST_W'($urandom_range(0, 15));
        r.hop_valid   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.cost = COST_W'($urandom_range(0, 40));
        else if (pick < 68)
            r.cost = COST_W'($urandom_range(0, 1023));
        else if (pick < 82)
            r.cost = INFINITE_COST;
        else if (pick < 90)
            r.cost = COST_W'($urandom_range(1000, 1023));
        else
            r.cost = COST_W'($urandom_range(90, 130));
        return r;
    endfunction

    // Write one configuration register and wait for it to be taken.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request went in and every result came back, then wait
    // SETTLE_CYCLES more so the block is idle again.
    task automatic drain_and_settle();
        while (pending_requests.size() != 0 || req_valid || expected_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    logic [METHOD_W-1:0]   phase_method [PHASE_COUNT];
    logic [CFG_DATA_W-1:0] phase_limit  [PHASE_COUNT];

    initial
    begin : stimulus
        dvr_req_t r;
        int       issued;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_register(CFG_ADVERT_METHOD, CFG_DATA_W'(METHOD_PLAIN));
        write_register(CFG_COUNT_LIMIT, COUNT_LIMIT_RESET);

        // Load every entry first so no request ever reads an unwritten one
        queue_request(make_request(MODE_LOAD, 4'd0, 4'd0, 10'd0, 1'b1));
        queue_request(make_request(MODE_LOAD, 4'd1, 4'd1, 10'd5, 1'b1));
        queue_request(make_request(MODE_LOAD, 4'd2, 4'd15, INFINITE_COST, 1'b0));
        // Costs above infinity saturate to infinity
        queue_request(make_request(MODE_LOAD, 4'd3, 4'd7, 10'd1023, 1'b0));
        queue_request(make_request(MODE_LOAD, 4'd4, 4'd4, 10'd1000, 1'b1));
        // Just over, at, and at the top of the over-limit band
        queue_request(make_request(MODE_LOAD, 4'd5, 4'd1, 10'd101, 1'b1));
        queue_request(make_request(MODE_LOAD, 4'd6, 4'd2, 10'd100, 1'b1));
        queue_request(make_request(MODE_LOAD, 4'd7, 4'd1, 10'd998, 1'b1));
        for (int d = 8; d < TABLE_DEPTH; d++)
            queue_request(make_request(MODE_LOAD, d[DEST_W-1:0],
                                       d[DEST_W-1:0] ^ 4'd5,
                                       10'(50 + 60 * d), d[0]));

        // Improve, then repeat the same advertisement: equal cost stays put
        queue_request(make_request(MODE_RECEIVE, 4'd2, 4'd1, 10'd10, 1'b0));
        queue_request(make_request(MODE_RECEIVE, 4'd2, 4'd1, 10'd10, 1'b1));
        queue_request(make_request(MODE_RECEIVE, 4'd7, 4'd2, 10'd1, 1'b0));
        // Unreachable sender: sum saturates, no update
        queue_request(make_request(MODE_RECEIVE, 4'd6, 4'd3, INFINITE_COST, 1'b0));
        queue_request(make_request(MODE_RECEIVE, 4'd5, 4'd4, 10'd1023, 1'b1));
        queue_request(make_request(MODE_RECEIVE, 4'd0, 4'd0, 10'd0, 1'b0));

        queue_request(make_request(MODE_ADVERTISE, 4'd0, 4'd1, 10'd0, 1'b0));
        // Mode three is dropped without a result
        queue_request(make_request(MODE_NOP, 4'd15, 4'd15, 10'd1023, 1'b1));
        queue_request(make_request(MODE_ADVERTISE, 4'd15, 4'd15, 10'd1023, 1'b1));
        drain_and_settle();

        // Walk the methods, with the limit extremes first
        phase_method[0] = METHOD_POISON;   phase_limit[0] = 10'd0;
        phase_method[1] = METHOD_SPLIT;    phase_limit[1] = 10'd998;
        phase_method[2] = METHOD_RESERVED; phase_limit[2] = 10'd500;
        phase_method[3] = METHOD_PLAIN;    phase_limit[3] = CFG_DATA_W'($urandom_range(0, 998));
        phase_method[4] = METHOD_POISON;   phase_limit[4] = CFG_DATA_W'($urandom_range(0, 998));
        phase_method[5] = METHOD_SPLIT;    phase_limit[5] = CFG_DATA_W'($urandom_range(0, 998));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_register(CFG_ADVERT_METHOD, CFG_DATA_W'(phase_method[p]));
            write_register(CFG_COUNT_LIMIT, phase_limit[p]);

            // Advertise back to the neighbor that several routes go through
            queue_request(make_request(MODE_ADVERTISE, 4'd3, 4'd1, 10'd0, 1'b0));
            issued = 0;
            while (issued < PHASE_REQUESTS)
            begin
                r = random_request();
                if ($urandom_range(0, 24) == 0)
                    r.mode = MODE_NOP;
                else
                    issued++;
                queue_request(r);
            end
            // Hold off results while this phase's requests keep coming
            if (p == 2)
                hold_off_arm = 1'b1;
            drain_and_settle();
        end

        if (expected_routes.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
